FILE: src/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants for the periodic tick scheduler
// Table geometry, command queue depth, function and result codes.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int SLOTS  = 16;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int QDEPTH = 2;
   localparam int QCNT_W = $clog2(QDEPTH + 1);
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_REG   = 2'd1;
   localparam logic [1:0] FUNC_DEREG = 2'd2;

   localparam logic [1:0] KIND_DUE      = 2'd0;
   localparam logic [1:0] KIND_ASSIGNED = 2'd1;
   localparam logic [1:0] KIND_FULL     = 2'd2;

   localparam logic [31:0] ID_FIRST = 32'd1;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_REG   = 2'd1,
      OP_DEREG = 2'd2
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [63:0] now_us;
      logic [31:0] interval_us;
      logic [31:0] target_id;
   } cmd_type;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] interval_us;
      logic [63:0] last_us;
   } entry_type;

endpackage

FILE: src/periodic_tick_scheduler.sv
// Periodic tick scheduler: keeps up to SLOTS periodic consumers in
// registration order. A register transaction is handled in the engine's idle
// state and answers with a new id (or a full refusal); a tick or deregister
// transaction walks the table through its single read port, one slot per
// cycle, a tick scan holding while a pending response is stalled. Due
// consumers come out in table order, the final one flagged with last;
// deregister and unused function codes give no response. A two-entry
// command queue lets requests be accepted while the engine is busy.
// ----------------------------------------------------------------------------
// periodic_tick_scheduler: top level
// Connects the request front end to the table engine.
// ----------------------------------------------------------------------------
module periodic_tick_scheduler import pts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_now_us,
   input  logic [31:0] req_interval_us,
   input  logic [31:0] req_target_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_consumer_id,
   output logic        rsp_last
);

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;

   pts_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_now_us      (req_now_us),
      .req_interval_us (req_interval_us),
      .req_target_id   (req_target_id),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_take        (cmd_take)
   );

   pts_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_take        (cmd_take),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_consumer_id (rsp_consumer_id),
      .rsp_last        (rsp_last)
   );

`ifndef NO_ASSERTIONS
   a_take_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid)
      else $error("engine took a command from an empty queue");

   a_full_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_FULL) |-> (rsp_consumer_id == '0 && rsp_last))
      else $error("full refusal must carry id zero and last");

   a_assigned_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_ASSIGNED) |-> (rsp_consumer_id != '0 && rsp_last))
      else $error("assigned id must be nonzero and last");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_kind)
                                    && $stable(rsp_consumer_id) && $stable(rsp_last)))
      else $error("stalled response changed");
`endif

endmodule

FILE: src/pts_front.sv
// ----------------------------------------------------------------------------
// pts_front: request intake and command queue
// Accepts request transactions, decodes the function code, drops unused
// codes and queues the rest for the table engine.
// ----------------------------------------------------------------------------
module pts_front import pts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_now_us,
   input  logic [31:0] req_interval_us,
   input  logic [31:0] req_target_id,
   output logic        cmd_valid,
   output cmd_type     cmd,
   input  logic        cmd_take
);

   cmd_type             q_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                known;
   logic                push;
   logic                pop;
   cmd_type             dec;

   always_comb begin
      known           = 1'b1;
      dec.op          = OP_TICK;
      dec.now_us      = req_now_us;
      dec.interval_us = req_interval_us;
      dec.target_id   = req_target_id;
      case (req_func)
         FUNC_TICK:  dec.op = OP_TICK;
         FUNC_REG:   dec.op = OP_REG;
         FUNC_DEREG: dec.op = OP_DEREG;
         default:    known = 1'b0;
      endcase
   end

   assign req_stall = (cnt_ff == QCNT_W'(QDEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];

   // unused function codes are accepted and dropped here
   assign push = req_valid && !req_stall && known;
   assign pop  = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

FILE: src/pts_back.sv
// ----------------------------------------------------------------------------
// pts_back: consumer table engine, driving the response output register
// Holds the consumer table, runs tick scans and deregister compaction one
// slot per cycle; a tick scan waits while a pending response is stalled.
// ----------------------------------------------------------------------------
module pts_back import pts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_take,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_consumer_id,
   output logic        rsp_last
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_TICK  = 3'b010,
      ST_DEREG = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   entry_type          table_ff [SLOTS];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   wptr_ff, wptr_in;
   logic [31:0]        next_id_ff, next_id_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [31:0]        pend_id_ff, pend_id_in;
   logic [63:0]        now_ff, now_in;
   logic [31:0]        target_ff, target_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_kind_ff;
   logic [31:0]        rsp_id_ff;
   logic               rsp_last_ff;

   logic               out_free;
   logic               push;
   logic [1:0]         push_kind;
   logic [31:0]        push_id;
   logic               push_last;
   logic               tbl_we;
   logic [IDX_W-1:0]   tbl_widx;
   entry_type          tbl_wdata;
   entry_type          cur;
   logic [63:0]        elapsed;
   logic               due;
   logic [31:0]        id_inc;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cur      = table_ff[idx_ff[IDX_W-1:0]];
   assign elapsed  = now_ff - cur.last_us;
   assign due      = elapsed > {32'd0, cur.interval_us};
   assign id_inc   = next_id_ff + 1'b1;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      wptr_in       = wptr_ff;
      next_id_in    = next_id_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      now_in        = now_ff;
      target_in     = target_ff;
      cmd_take      = 1'b0;
      push          = 1'b0;
      push_kind     = KIND_DUE;
      push_id       = pend_id_ff;
      push_last     = 1'b0;
      tbl_we        = 1'b0;
      tbl_widx      = idx_ff[IDX_W-1:0];
      tbl_wdata     = cur;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_take  = 1'b1;
               now_in    = cmd.now_us;
               target_in = cmd.target_id;
               idx_in    = '0;
               wptr_in   = '0;
               case (cmd.op)
                  OP_TICK: begin
                     pend_valid_in = 1'b0;
                     state_in      = ST_TICK;
                  end
                  OP_REG: begin
                     push      = 1'b1;
                     push_last = 1'b1;
                     if (count_ff >= CNT_W'(SLOTS)) begin
                        push_kind = KIND_FULL;
                        push_id   = '0;
                     end else begin
                        push_kind             = KIND_ASSIGNED;
                        push_id               = next_id_ff;
                        tbl_we                = 1'b1;
                        tbl_widx              = count_ff[IDX_W-1:0];
                        tbl_wdata.id          = next_id_ff;
                        tbl_wdata.interval_us = cmd.interval_us;
                        tbl_wdata.last_us     = cmd.now_us;
                        count_in              = count_ff + 1'b1;
                        // id zero is never handed out
                        next_id_in = (id_inc == '0) ? ID_FIRST : id_inc;
                     end
                  end
                  OP_DEREG: state_in = ST_DEREG;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_TICK: begin
            if (out_free) begin
               if (idx_ff == count_ff) begin
                  // flush the held due entry as the final result
                  if (pend_valid_ff) begin
                     push      = 1'b1;
                     push_last = 1'b1;
                  end
                  state_in = ST_IDLE;
               end else begin
                  if (due) begin
                     tbl_we            = 1'b1;
                     tbl_wdata.last_us = now_ff;
                     push              = pend_valid_ff;
                     pend_valid_in     = 1'b1;
                     pend_id_in        = cur.id;
                  end
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_DEREG: begin
            if (idx_ff == count_ff) begin
               count_in = wptr_ff;
               state_in = ST_IDLE;
            end else begin
               if (cur.id != target_ff) begin
                  tbl_we   = 1'b1;
                  tbl_widx = wptr_ff[IDX_W-1:0];
                  wptr_in  = wptr_ff + 1'b1;
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         idx_ff        <= '0;
         wptr_ff       <= '0;
         next_id_ff    <= ID_FIRST;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         wptr_ff       <= wptr_in;
         next_id_ff    <= next_id_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_id_ff <= pend_id_in;
      now_ff     <= now_in;
      target_ff  <= target_in;
      if (push) begin
         rsp_kind_ff <= push_kind;
         rsp_id_ff   <= push_id;
         rsp_last_ff <= push_last;
      end
      if (tbl_we) begin
         table_ff[tbl_widx] <= tbl_wdata;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_consumer_id = rsp_id_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
